// ===== src/cle_pkg.sv =====
// cle_pkg: shared constants, codes and types of the console line editor.
// Used by cle_cell, cle_row and console_line_editor; depends on nothing.
`default_nettype none

package cle_pkg;

  // Line storage geometry
  localparam int LINE_DEPTH = 128;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int LEN_W      = IDX_W + 1;
  // Common width for length, limit and index compares
  localparam int CMP_W      = (LEN_W > 8) ? LEN_W : 8;

  // Request codes
  localparam logic [1:0] FUNC_KEY     = 2'd0;
  localparam logic [1:0] FUNC_PROMPT  = 2'd1;
  localparam logic [1:0] FUNC_PRELOAD = 2'd2;
  localparam logic [1:0] FUNC_READ    = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_TERM  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Key codes
  localparam logic [7:0] KEY_NUL       = 8'h00;
  localparam logic [7:0] KEY_BS        = 8'h08;
  localparam logic [7:0] KEY_CTRL_U    = 8'h15;
  localparam logic [7:0] KEY_CTRL_W    = 8'h17;
  localparam logic [7:0] KEY_CTRL_X    = 8'h18;
  localparam logic [7:0] KEY_SPACE     = 8'h20;
  localparam logic [7:0] KEY_PRINT_LO  = 8'h20;
  localparam logic [7:0] KEY_PRINT_HI  = 8'h7E;
  localparam logic [7:0] KEY_DEL       = 8'h7F;

  // Control from the sequencer to the row of character cells
  typedef struct packed {
    logic              shift;
    logic              wr_en;
    logic [CHAR_W-1:0] wr_data;
  } cle_row_ctl_t;

endpackage

`default_nettype wire

// ===== src/console_line_editor.sv =====
// console_line_editor: top level; configuration registers, item sequencer
// and result register around the ring of character cells.
// Depends on cle_pkg and cle_row.
//
//   port group | direction | handshake                  | payload
//   in_        | to block  | in_valid / in_stall        | func, key, read_index
//   out_       | from block| out_valid / out_stall      | status, ended_by,
//              |           |                            | line_length, read_char,
//              |           |                            | preinit_active
//   apb        | to block  | psel, penable, pwrite      | paddr, pwdata, prdata
//
// Every item is accepted in S_IDLE, makes one full rotation of the cell ring in
// S_PASS (one line position past the tap per cycle), and commits its result in
// S_FIN. One item is in work at a time; a new item is taken
// while the previous result still waits in the output register.
// Reset clears length and preinit flag and restores the configuration
// defaults; the cells are not cleared. A stalled output delays the commit
// cycle until it is taken.
`default_nettype none

module console_line_editor (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_key,
  input  wire logic [6:0] in_read_index,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [1:0] out_status,
  output logic      [7:0] out_ended_by,
  output logic      [7:0] out_line_length,
  output logic      [7:0] out_read_char,
  output logic            out_preinit_active,
  // Configuration port
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic            pready
);
  import cle_pkg::*;

  // Register indexes
  localparam logic [2:0] REG_MAX_LEN = 3'd0;
  localparam logic [2:0] REG_TERM_A  = 3'd1;
  localparam logic [2:0] REG_TERM_B  = 3'd2;
  localparam logic [2:0] REG_TERM_C  = 3'd3;
  localparam logic [2:0] REG_TERM_D  = 3'd4;

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(LINE_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_PASS, S_FIN} state_t;
  typedef enum logic [1:0] {OP_NONE, OP_WRITE, OP_READ, OP_WORD} op_t;

  state_t            state_r;
  op_t               op_r, op_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [CHAR_W-1:0] key_r;
  logic [1:0]        status_r, status_nxt;
  logic [7:0]        ended_r, ended_nxt;
  logic [LEN_W-1:0]  len_new_r, len_new_nxt;
  logic              pre_new_r, pre_new_nxt;
  logic [IDX_W-1:0]  step_r;
  logic              sp_valid_r;
  logic [IDX_W-1:0]  sp_pos_r;
  logic [LEN_W-1:0]  res_r;
  logic [CHAR_W-1:0] rd_r;

  logic [LEN_W-1:0]  length_r;
  logic              preinit_r;
  logic [7:0]        max_length_r, term_a_r, term_b_r, term_c_r, term_d_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [7:0]        out_ended_r, out_len_r, out_char_r;
  logic              out_pre_r;
  logic              commit;

  cle_row_ctl_t      row_ctl;
  logic [CHAR_W-1:0] tap;

  // Configuration port
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    case (cfg_idx)
      REG_MAX_LEN: prdata = {24'd0, max_length_r};
      REG_TERM_A:  prdata = {24'd0, term_a_r};
      REG_TERM_B:  prdata = {24'd0, term_b_r};
      REG_TERM_C:  prdata = {24'd0, term_c_r};
      REG_TERM_D:  prdata = {24'd0, term_d_r};
      default:     prdata = 32'd0;
    endcase
  end

  // Decode the offered item against the current line
  logic [CMP_W-1:0] lim, len_ext, idx_ext;
  logic             full, printable, is_term;

  always_comb begin
    len_ext   = CMP_W'(length_r);
    idx_ext   = CMP_W'(in_read_index);
    lim       = (CMP_W'(max_length_r) < CMP_W'(LINE_DEPTH)) ?
                CMP_W'(max_length_r) : CMP_W'(LINE_DEPTH);
    full      = len_ext >= lim;
    printable = (in_key >= KEY_PRINT_LO) && (in_key <= KEY_PRINT_HI);
    is_term   = (in_key == KEY_NUL) || (in_key == term_a_r) || (in_key == term_b_r) ||
                (in_key == term_c_r) || (in_key == term_d_r);

    op_nxt      = OP_NONE;
    pos_nxt     = IDX_W'(length_r);
    status_nxt  = ST_OK;
    ended_nxt   = 8'd0;
    len_new_nxt = length_r;
    pre_new_nxt = preinit_r;

    case (in_func)
      FUNC_KEY: begin
        if (is_term) begin
          status_nxt = ST_TERM;
          ended_nxt  = in_key;
        end else if (printable && full) begin
          status_nxt = ST_FULL;
        end else if (preinit_r && printable) begin
          op_nxt      = OP_WRITE;
          pos_nxt     = '0;
          len_new_nxt = LEN_W'(1);
          pre_new_nxt = 1'b0;
        end else if ((in_key == KEY_BS) || (in_key == KEY_DEL)) begin
          if (length_r != '0) begin
            len_new_nxt = length_r - LEN_W'(1);
          end
        end else if (in_key == KEY_CTRL_W) begin
          op_nxt = OP_WORD;
        end else if ((in_key == KEY_CTRL_U) || (in_key == KEY_CTRL_X)) begin
          len_new_nxt = '0;
        end else if (printable && (len_ext < CMP_W'(LINE_DEPTH))) begin
          op_nxt      = OP_WRITE;
          len_new_nxt = length_r + LEN_W'(1);
        end
      end
      FUNC_PROMPT: begin
        len_new_nxt = '0;
        pre_new_nxt = 1'b0;
      end
      FUNC_PRELOAD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op_nxt      = OP_WRITE;
          len_new_nxt = length_r + LEN_W'(1);
          pre_new_nxt = 1'b1;
        end
      end
      FUNC_READ: begin
        if ((idx_ext >= len_ext) || (idx_ext >= CMP_W'(LINE_DEPTH))) begin
          status_nxt = ST_RANGE;
        end else begin
          op_nxt  = OP_READ;
          pos_nxt = IDX_W'(in_read_index);
        end
      end
      default: begin
        op_nxt = OP_NONE;
      end
    endcase
  end

  // Drive the cell ring during the rotation
  always_comb begin
    row_ctl.shift   = (state_r == S_PASS);
    row_ctl.wr_en   = (state_r == S_PASS) && (op_r == OP_WRITE) && (step_r == pos_r);
    row_ctl.wr_data = key_r;
  end

  cle_row u_row (
    .clk (clk),
    .ctl (row_ctl),
    .tap (tap)
  );

  assign in_stall = (state_r != S_IDLE);

  // Commit once the result register is free or being emptied
  assign commit = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // Sequencer, line state, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      length_r     <= '0;
      preinit_r    <= 1'b0;
      max_length_r <= 8'd128;
      term_a_r     <= 8'd10;
      term_b_r     <= 8'd13;
      term_c_r     <= 8'd27;
      term_d_r     <= 8'd9;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_MAX_LEN: max_length_r <= pwdata[7:0];
          REG_TERM_A:  term_a_r     <= pwdata[7:0];
          REG_TERM_B:  term_b_r     <= pwdata[7:0];
          REG_TERM_C:  term_c_r     <= pwdata[7:0];
          REG_TERM_D:  term_d_r     <= pwdata[7:0];
          default:     ;
        endcase
      end

      // Raise the result on commit, drop it once taken
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= op_nxt;
            pos_r      <= pos_nxt;
            key_r      <= in_key;
            status_r   <= status_nxt;
            ended_r    <= ended_nxt;
            len_new_r  <= len_new_nxt;
            pre_new_r  <= pre_new_nxt;
            step_r     <= '0;
            sp_valid_r <= 1'b0;
            sp_pos_r   <= '0;
            res_r      <= '0;
            rd_r       <= '0;
            state_r    <= S_PASS;
          end
        end
        S_PASS: begin
          step_r <= step_r + IDX_W'(1);
          // Capture the requested character as it passes the tap
          if ((op_r == OP_READ) && (step_r == pos_r)) begin
            rd_r <= tap;
          end
          // Word delete: track the last space before each non-space
          if ((op_r == OP_WORD) && (LEN_W'(step_r) < length_r)) begin
            if (tap == KEY_SPACE) begin
              sp_valid_r <= 1'b1;
              sp_pos_r   <= step_r;
            end else begin
              res_r <= sp_valid_r ? LEN_W'(sp_pos_r) : '0;
            end
          end
          if (step_r == LAST_STEP) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (commit) begin
            out_status_r <= status_r;
            out_ended_r  <= ended_r;
            out_len_r    <= (op_r == OP_WORD) ? 8'(res_r) : 8'(len_new_r);
            out_char_r   <= rd_r;
            out_pre_r    <= pre_new_r;
            length_r     <= (op_r == OP_WORD) ? res_r : len_new_r;
            preinit_r    <= pre_new_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_ended_by       = out_ended_r;
  assign out_line_length    = out_len_r;
  assign out_read_char      = out_char_r;
  assign out_preinit_active = out_pre_r;

`ifndef SYNTH
  // An accepted item keeps the input closed for its rotation
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after an accepted item");

  // The rotation ends after exactly one full turn
  a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS && step_r == LAST_STEP) |=> (state_r == S_FIN))
    else $error("rotation did not end at the last step");

  // The line never grows beyond its storage
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CMP_W'(out_line_length) <= CMP_W'(LINE_DEPTH)))
    else $error("line length beyond storage depth");

  // Only a terminated line reports a terminator
  a_ended_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_TERM) |-> (out_ended_by == 8'd0))
    else $error("terminator reported without termination");

  // A character is read back only with an ok status
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_char == 8'd0))
    else $error("character returned with a failing status");
`endif

endmodule

`default_nettype wire

// ===== src/cle_cell.sv =====
// cle_cell: one character cell of the line row.
// Depends on cle_pkg for the character width.
`default_nettype none

module cle_cell (
  input  wire logic                      clk,
  input  wire logic                      shift,
  input  wire logic [cle_pkg::CHAR_W-1:0] din,
  output logic      [cle_pkg::CHAR_W-1:0] dout
);
  import cle_pkg::*;

  logic [CHAR_W-1:0] char_r;

  // Take the neighbour's character on every shift, hold otherwise
  always_ff @(posedge clk) begin
    if (shift) begin
      char_r <= din;
    end
  end

  assign dout = char_r;

endmodule

`default_nettype wire

// ===== src/cle_row.sv =====
// cle_row: ring of LINE_DEPTH character cells; the tap at cell 0 sees one
// line position per shift and a new character may enter at the far end.
// Depends on cle_pkg and cle_cell.
`default_nettype none

module cle_row (
  input  wire logic                      clk,
  input  wire cle_pkg::cle_row_ctl_t     ctl,
  output logic      [cle_pkg::CHAR_W-1:0] tap
);
  import cle_pkg::*;

  logic [CHAR_W-1:0] link [LINE_DEPTH];
  logic [CHAR_W-1:0] entry;

  // Replace the character leaving the tap when a write is due
  assign entry = ctl.wr_en ? ctl.wr_data : link[0];
  assign tap   = link[0];

  for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
    if (i == LINE_DEPTH - 1) begin : g_last
      cle_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .din   (entry),
        .dout  (link[i])
      );
    end else begin : g_mid
      cle_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .din   (link[i+1]),
        .dout  (link[i])
      );
    end
  end

endmodule

`default_nettype wire
